// ----- hw/rtl/mt64_pkg.sv -----
// Shared constants, types and functions of the MT19937-64 generator.
package mt64_pkg;

   // Table geometry
   localparam int unsigned TABLE_WORDS = 312;
   localparam int unsigned MID_OFFSET  = 156;
   localparam int unsigned IDX_W       = $clog2(TABLE_WORDS);
   localparam int unsigned WORD_W      = 64;
   localparam int unsigned COUNT_W     = 7;

   // Recurrence and tempering constants
   localparam logic [63:0] TWIST_XOR  = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] TEMPER_D   = 64'h5555_5555_5555_5555;
   localparam logic [63:0] TEMPER_B   = 64'h71D6_7FFF_EDA6_0000;
   localparam logic [63:0] TEMPER_C   = 64'hFFF7_EEE0_0000_0000;
   localparam logic [63:0] INIT_MULT  = 64'd6364136223846793005;
   localparam logic [63:0] LOW_MASK   = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] HIGH_MASK  = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] RESET_SEED = 64'd5489;
   localparam int unsigned TEMPER_U   = 29;
   localparam int unsigned TEMPER_S   = 17;
   localparam int unsigned TEMPER_T   = 37;
   localparam int unsigned TEMPER_L   = 43;

   // Partial-product step of the seeding multiply
   typedef enum logic [1:0] {
      MUL_LO,
      MUL_HI_A,
      MUL_HI_B
   } mul_phase_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              seed_write;
      logic              mul_en;
      mul_phase_type     mul_phase;
      logic              req_take;
      logic              read_pair;
      logic              read_mid;
      logic              twist_write;
      logic              out_load;
      logic [IDX_W-1:0]  idx;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } status_type;

   // Temper one table word
   function automatic logic [63:0] temper(input logic [63:0] w);
      logic [63:0] y;
      y = w;
      y = y ^ ((y >> TEMPER_U) & TEMPER_D);
      y = y ^ ((y << TEMPER_S) & TEMPER_B);
      y = y ^ ((y << TEMPER_T) & TEMPER_C);
      y = y ^ (y >> TEMPER_L);
      return y;
   endfunction

   // Keep the top n bits, right-aligned; zero bits gives zero, 64 and up gives all
   function automatic logic [63:0] take_bits(input logic [63:0] y,
                                             input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] amt;
      amt = COUNT_W'(7'd64) - n;
      if (n == '0) begin
         return '0;
      end else if (n[COUNT_W-1]) begin
         return y;
      end else begin
         return y >> amt[5:0];
      end
   endfunction

endpackage

// ----- hw/rtl/mt64_ctrl.sv -----
// Sequencer for seeding the table and for serving one item at a time.
module mt64_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mt64_pkg::status_type    status,
   output mt64_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_SEED,
      S_MUL_LO,
      S_MUL_HA,
      S_MUL_HB,
      S_IDLE,
      S_READ_PAIR,
      S_READ_MID,
      S_TWIST,
      S_DELIVER
   } state_type;

   state_type                     state_ff, state_in;
   logic [mt64_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          idx_last;

   assign idx_last  = (idx_ff == mt64_pkg::IDX_W'(mt64_pkg::TABLE_WORDS - 1));
   assign req_stall = (state_ff != S_IDLE);

   // Decode state into datapath commands and next state
   always_comb begin
      cmd           = '0;
      cmd.mul_phase = mt64_pkg::MUL_LO;
      cmd.idx       = idx_ff;
      state_in      = state_ff;
      idx_in        = idx_ff;
      unique case (state_ff)
         S_SEED: begin
            cmd.seed_write = 1'b1;
            idx_in         = mt64_pkg::IDX_W'(1);
            state_in       = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = mt64_pkg::MUL_LO;
            state_in      = S_MUL_HA;
         end
         S_MUL_HA: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = mt64_pkg::MUL_HI_A;
            state_in      = S_MUL_HB;
         end
         S_MUL_HB: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = mt64_pkg::MUL_HI_B;
            if (idx_last) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + mt64_pkg::IDX_W'(1);
               state_in = S_MUL_LO;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_take = 1'b1;
               state_in     = S_READ_PAIR;
            end
         end
         S_READ_PAIR: begin
            cmd.read_pair = 1'b1;
            state_in      = S_READ_MID;
         end
         S_READ_MID: begin
            cmd.read_mid = 1'b1;
            state_in     = S_TWIST;
         end
         S_TWIST: begin
            cmd.twist_write = 1'b1;
            state_in        = S_DELIVER;
         end
         S_DELIVER: begin
            // Hold until the output register can take the item
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               idx_in       = idx_last ? '0 : idx_ff + mt64_pkg::IDX_W'(1);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_SEED;
         end
      endcase
      // Seed write restarts the fill
      if (csr_write_enable) begin
         state_in = S_SEED;
         idx_in   = '0;
      end
   end

   // Hold state and table index
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SEED;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- hw/rtl/mt64_datapath.sv -----
// State table, seeding multiply, per-element twist, tempering and output register.
module mt64_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [63:0]                       csr_write_data,
   input  logic [mt64_pkg::COUNT_W-1:0]      req_bit_count,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [63:0]                       rsp_random_value,
   input  mt64_pkg::cmd_type                 cmd,
   output mt64_pkg::status_type              status
);

   logic [63:0] table_mem [mt64_pkg::TABLE_WORDS];

   logic [63:0]                      seed_ff;
   logic [63:0]                      prev_ff;
   logic [63:0]                      acc_ff, acc_in;
   logic [63:0]                      rd_a_ff, rd_b_ff;
   logic [63:0]                      x_ff;
   logic [63:0]                      y_ff;
   logic [mt64_pkg::COUNT_W-1:0]     count_ff;
   logic                             rsp_valid_ff;
   logic [63:0]                      rsp_value_ff;

   logic [mt64_pkg::IDX_W-1:0]       next_addr, mid_addr, rd_a_addr;
   logic [63:0]                      mix_x;
   logic [63:0]                      twisted;
   logic [63:0]                      seed_x;
   logic [31:0]                      mul_a, mul_b;
   logic [63:0]                      prod;
   logic [63:0]                      init_word;
   logic                             mem_we;
   logic [63:0]                      mem_wdata;

   // Neighbor and mid-table addresses of the current index
   assign next_addr = (cmd.idx == mt64_pkg::IDX_W'(mt64_pkg::TABLE_WORDS - 1)) ?
                      '0 : cmd.idx + mt64_pkg::IDX_W'(1);
   assign mid_addr  = (cmd.idx < mt64_pkg::IDX_W'(mt64_pkg::MID_OFFSET)) ?
                      cmd.idx + mt64_pkg::IDX_W'(mt64_pkg::MID_OFFSET) :
                      cmd.idx - mt64_pkg::IDX_W'(mt64_pkg::MID_OFFSET);
   assign rd_a_addr = cmd.read_mid ? mid_addr : cmd.idx;

   // Seeding multiply: one 32x32 partial product per step
   assign seed_x = prev_ff ^ (prev_ff >> 62);
   assign mul_a  = (cmd.mul_phase == mt64_pkg::MUL_HI_A) ? seed_x[63:32] : seed_x[31:0];
   assign mul_b  = (cmd.mul_phase == mt64_pkg::MUL_HI_B) ?
                   mt64_pkg::INIT_MULT[63:32] : mt64_pkg::INIT_MULT[31:0];
   assign prod      = 64'(mul_a) * 64'(mul_b);
   assign init_word = acc_ff + {prod[31:0], 32'b0};

   always_comb begin
      case (cmd.mul_phase)
         mt64_pkg::MUL_LO:   acc_in = prod + 64'(cmd.idx);
         mt64_pkg::MUL_HI_A: acc_in = init_word;
         default:            acc_in = acc_ff;
      endcase
   end

   // Twist one element from its word, its neighbor and the mid word
   assign mix_x   = (rd_a_ff & mt64_pkg::HIGH_MASK) | (rd_b_ff & mt64_pkg::LOW_MASK);
   assign twisted = rd_a_ff ^ (x_ff >> 1) ^ (x_ff[0] ? mt64_pkg::TWIST_XOR : 64'b0);

   // Select table write
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = twisted;
      if (cmd.seed_write) begin
         mem_we    = 1'b1;
         mem_wdata = seed_ff;
      end else if (cmd.mul_en && cmd.mul_phase == mt64_pkg::MUL_HI_B) begin
         mem_we    = 1'b1;
         mem_wdata = init_word;
      end else if (cmd.twist_write) begin
         mem_we = 1'b1;
      end
   end

   // State table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[cmd.idx] <= mem_wdata;
      end
      if (cmd.read_pair || cmd.read_mid) begin
         rd_a_ff <= table_mem[rd_a_addr];
      end
      if (cmd.read_pair) begin
         rd_b_ff <= table_mem[next_addr];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.seed_write) begin
         prev_ff <= seed_ff;
      end else if (cmd.mul_en && cmd.mul_phase == mt64_pkg::MUL_HI_B) begin
         prev_ff <= init_word;
      end
      if (cmd.mul_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.read_mid) begin
         x_ff <= mix_x;
      end
      if (cmd.twist_write) begin
         y_ff <= twisted;
      end
      if (cmd.req_take) begin
         count_ff <= req_bit_count;
      end
      if (cmd.out_load) begin
         rsp_value_ff <= mt64_pkg::take_bits(mt64_pkg::temper(y_ff), count_ff);
      end
   end

   // Seed register and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= mt64_pkg::RESET_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            seed_ff <= csr_write_data;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

endmodule

// ----- hw/rtl/mersenne_twister_64_prng_unit.sv -----
// MT19937-64 generator top level: seed register port, request and result channels.
// Each accepted request is served by two table reads (three reads over two ports),
// the twist write and the output load, which waits while the result channel stalls;
// no new request is accepted until the item is loaded. Reset or a seed write fills
// the table (one write, then 3 multiply steps for each of the other 311 words) while
// requests stall. Reset is synchronous, active high, and loads seed 5489.
module mersenne_twister_64_prng_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [63:0]                     csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mt64_pkg::COUNT_W-1:0]    req_bit_count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [63:0]                     rsp_random_value
);

   mt64_pkg::cmd_type    cmd;
   mt64_pkg::status_type status;

   mt64_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .status           (status),
      .cmd              (cmd)
   );

   mt64_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bit_count    (req_bit_count),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_random_value (rsp_random_value),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the MT19937-64 generator: predicts each random value and checks it.
module tb;

   localparam int unsigned WORDS           = 312;
   localparam int unsigned HALF_WAY        = 156;
   localparam logic [63:0] MT_A            = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] MT_D            = 64'h5555_5555_5555_5555;
   localparam logic [63:0] MT_B            = 64'h71D6_7FFF_EDA6_0000;
   localparam logic [63:0] MT_C            = 64'hFFF7_EEE0_0000_0000;
   localparam logic [63:0] MT_F            = 64'd6364136223846793005;
   localparam logic [63:0] LOWER_BITS      = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] UPPER_BITS      = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] DEFAULT_SEED    = 64'd5489;
   localparam int unsigned CNT_W           = mt64_pkg::COUNT_W;
   localparam int unsigned LIMIT_CYCLES    = 800000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned DRAIN_CYCLES    = 20;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [63:0]      csr_write_data;
   logic             req_valid;
   logic             req_stall;
   logic [CNT_W-1:0] req_bit_count;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [63:0]      rsp_random_value;

   // Predictor state: word table and read cursor
   logic [63:0]      mt_words [0:WORDS-1];
   int unsigned      mt_cursor;
   logic [63:0]      predicted_values [$];

   int unsigned      error_count;
   int unsigned      cycle_count;
   int unsigned      hold_off_requests;
   int unsigned      hold_off_served;

   mersenne_twister_64_prng_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bit_count    (req_bit_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   always #2 clock = ~clock;

   // Fill the table from a seed; the first draw twists
   function automatic void seed_words(input logic [63:0] seed_value);
      int k;
      logic [63:0] prev;
      mt_words[0] = seed_value;
      for (k = 1; k < WORDS; k++) begin
         prev = mt_words[k-1];
         mt_words[k] = MT_F * (prev ^ (prev >> 62)) + 64'(k);
      end
      mt_cursor = WORDS;
   endfunction

   // Twist the whole table in place
   function automatic void twist_words();
      int k;
      logic [63:0] x;
      logic [63:0] xa;
      for (k = 0; k < WORDS; k++) begin
         x = (mt_words[k] & UPPER_BITS) | (mt_words[(k + 1) % WORDS] & LOWER_BITS);
         xa = x >> 1;
         if (x[0]) begin
            xa = xa ^ MT_A;
         end
         mt_words[k] = mt_words[(k + HALF_WAY) % WORDS] ^ xa;
      end
      mt_cursor = 0;
   endfunction

   // Consume one word, temper it and keep the top n bits
   function automatic logic [63:0] draw_random_value(input logic [CNT_W-1:0] n);
      logic [63:0] y;
      if (mt_cursor >= WORDS) begin
         twist_words();
      end
      y = mt_words[mt_cursor];
      mt_cursor++;
      y = y ^ ((y >> 29) & MT_D);
      y = y ^ ((y << 17) & MT_B);
      y = y ^ ((y << 37) & MT_C);
      y = y ^ (y >> 43);
      if (n == 0) begin
         return 64'd0;
      end else if (n >= 64) begin
         return y;
      end else begin
         return y >> (64 - int'(n));
      end
   endfunction

   // Mostly in-range bit counts, with zero and oversize counts mixed in
   function automatic logic [CNT_W-1:0] random_count();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         return CNT_W'($urandom_range(1, 64));
      end else if (pick < 92) begin
         return CNT_W'($urandom_range(65, 127));
      end else if (pick < 96) begin
         return '0;
      end else begin
         return CNT_W'(64);
      end
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int unsigned random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   // Offer one item and hold it until accepted
   task automatic send_item(input logic [CNT_W-1:0] n);
      @(negedge clock);
      req_valid <= 1'b1;
      req_bit_count <= n;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Drop valid for a number of cycles
   task automatic pause_sender(input int unsigned span);
      if (span > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (span - 1) @(negedge clock);
      end
   endtask

   // Write the seed once every outstanding item has come back
   task automatic write_seed(input logic [63:0] seed_value);
      while (predicted_values.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= seed_value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random bit counts with random gaps, and a gap-free stretch every 150 items
   task automatic run_stream(input int unsigned items);
      int unsigned i;
      for (i = 0; i < items; i++) begin
         send_item(random_count());
         if ((i % 150) >= 30) begin
            pause_sender(random_gap());
         end
      end
      pause_sender(1);
   endtask

   // Extremes and oddities of the bit count on the reset seed
   task automatic test_reset_seed_counts();
      logic [CNT_W-1:0] counts [16] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd63, 7'd2,
                                         7'd32, 7'd33, 7'd64, 7'd96, 7'd31, 7'd16,
                                         7'd48, 7'd1, 7'd64};
      int i;
      for (i = 0; i < 16; i++) begin
         send_item(counts[i]);
         pause_sender(random_gap());
      end
      pause_sender(1);
   endtask

   // Long random stream crossing two table twists
   task automatic test_random_counts();
      run_stream(650);
   endtask

   // Hold the receiver off while items keep coming so the block backs up
   task automatic test_backpressure();
      int i;
      hold_off_requests++;
      for (i = 0; i < 60; i++) begin
         send_item(random_count());
      end
      pause_sender(1);
   endtask

   // Reseed with the extremes, a random value and the default
   task automatic test_seed_writes();
      write_seed(64'd0);
      run_stream(300);
      write_seed({64{1'b1}});
      run_stream(300);
      write_seed({$urandom, $urandom});
      run_stream(300);
      write_seed(DEFAULT_SEED);
      run_stream(20);
   endtask

   // Predict accepted items and check returned ones
   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         seed_words(DEFAULT_SEED);
         predicted_values.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_values.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got %h",
                        $time, rsp_random_value);
            end else begin
               want = predicted_values.pop_front();
               if (rsp_random_value !== want) begin
                  error_count++;
                  $display("%0t: random_value mismatch, expected %h, got %h",
                           $time, want, rsp_random_value);
               end
            end
         end
         if (csr_write_enable) begin
            seed_words(csr_write_data);
         end
         if (req_valid && !req_stall) begin
            predicted_values.push_back(draw_random_value(req_bit_count));
         end
      end
   end

   // Receiver: random stall runs, plus a long hold-off when asked
   initial begin
      int unsigned pick;
      int unsigned span;
      logic level;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_served != hold_off_requests) begin
            hold_off_served++;
            level = 1'b1;
            span = HOLD_OFF_CYCLES;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               level = 1'b0;
               span = $urandom_range(1, 40);
            end else if (pick < 90) begin
               level = 1'b1;
               span = $urandom_range(1, 3);
            end else if (pick < 97) begin
               level = 1'b1;
               span = $urandom_range(4, 12);
            end else begin
               level = 1'b1;
               span = $urandom_range(20, 60);
            end
         end
         rsp_stall <= level;
         repeat (span - 1) @(negedge clock);
      end
   end

   // Stop a hung run
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_bit_count = '0;
      error_count = 0;
      cycle_count = 0;
      hold_off_requests = 0;
      hold_off_served = 0;
      mt_cursor = WORDS;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_reset_seed_counts();
      test_random_counts();
      test_backpressure();
      test_seed_writes();

      // Drain outstanding items, then let the pipeline settle
      while (predicted_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/mt64_pkg.sv
hw/rtl/mt64_ctrl.sv
hw/rtl/mt64_datapath.sv
hw/rtl/mersenne_twister_64_prng_unit.sv
tb/tb.sv
